// File: rtl/min_max_heap_priority_queue_top_macros.svh
// Assertion macros shared by the checker of the min-max heap priority queue.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef MIN_MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MIN_MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define MMHPQ_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("always check failed");

// A condition that must hold in the cycle after its antecedent.
`define MMHPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: rtl/mmhpq_pkg.sv
// Shared types, operation codes and status codes of the min-max heap queue.
// Depends on nothing.
package mmhpq_pkg;

   typedef struct packed {
      logic [30:0]        num;
      logic signed [31:0] pri;
   } entry_type;

   localparam int OP_W = 5;
   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_NONE       = 5'd0;
   localparam op_type OP_ACCEPT     = 5'd1;
   localparam op_type OP_INS_FULL   = 5'd2;
   localparam op_type OP_INS_START  = 5'd3;
   localparam op_type OP_EMPTY      = 5'd4;
   localparam op_type OP_RMIN_START = 5'd5;
   localparam op_type OP_RMAX_START = 5'd6;
   localparam op_type OP_MX2        = 5'd7;
   localparam op_type OP_MX3        = 5'd8;
   localparam op_type OP_RM_R       = 5'd9;
   localparam op_type OP_RM_L       = 5'd10;
   localparam op_type OP_MX_ROOT    = 5'd11;
   localparam op_type OP_TR_START   = 5'd12;
   localparam op_type OP_TR_SCAN    = 5'd13;
   localparam op_type OP_TR_CMP     = 5'd14;
   localparam op_type OP_TR_DEC     = 5'd15;
   localparam op_type OP_TR_PAR     = 5'd16;
   localparam op_type OP_INS_P      = 5'd17;
   localparam op_type OP_BUB        = 5'd18;
   localparam op_type OP_BUB_G      = 5'd19;
   localparam op_type OP_WRX        = 5'd20;
   localparam op_type OP_OUT        = 5'd21;

   typedef struct packed {
      op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic insert_cmd;
      logic min_cmd;
      logic full;
      logic empty;
      logic cnt_le2;
      logic mi_live;
      logic mi_is1;
      logic k_done;
      logic cand_live;
      logic m_eq_i;
      logic m_grand;
      logic i_gt3;
      logic bub_swap;
   } dp_status_type;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_MAX      = 3'd1;
   localparam logic [2:0] ST_MIN      = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   localparam logic [1:0] CMD_INSERT   = 2'd0;
   localparam logic [1:0] CMD_TAKE_MAX = 2'd1;
   localparam logic [1:0] CMD_TAKE_MIN = 2'd2;
   localparam logic [1:0] CMD_ODD_MIN  = 2'd3;

endpackage

// File: rtl/mmhpq_ifs.sv
// Valid/ready channel interfaces for command words and result words.
// Depends on nothing.
interface mmhpq_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [30:0]        job_number;
   logic signed [31:0] job_priority;
   modport source (output valid, command, job_number, job_priority, input ready);
   modport sink (input valid, command, job_number, job_priority, output ready);
endinterface

interface mmhpq_rsp_if #(parameter int CW = 11);
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [30:0]        removed_number;
   logic signed [31:0] removed_priority;
   logic [CW-1:0]      waiting_count;
   modport source (output valid, status, removed_number, removed_priority, waiting_count,
                   input ready);
   modport sink (input valid, status, removed_number, removed_priority, waiting_count,
                 output ready);
endinterface

// File: rtl/mmhpq_ctrl.sv
// Sequencer of the min-max heap queue: steps one command through its operations.
// Depends on mmhpq_pkg.
module mmhpq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mmhpq_pkg::dp_status_type stat,
   output mmhpq_pkg::ctrl_cmd_type  cmd
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DISP     = 5'd1;
   localparam logic [4:0] S_INS_P    = 5'd2;
   localparam logic [4:0] S_BUB      = 5'd3;
   localparam logic [4:0] S_BUB_G    = 5'd4;
   localparam logic [4:0] S_WRX      = 5'd5;
   localparam logic [4:0] S_MX2      = 5'd6;
   localparam logic [4:0] S_MX3      = 5'd7;
   localparam logic [4:0] S_RM_R     = 5'd8;
   localparam logic [4:0] S_RM_L     = 5'd9;
   localparam logic [4:0] S_MX_ROOT  = 5'd10;
   localparam logic [4:0] S_TR_START = 5'd11;
   localparam logic [4:0] S_TR_SCAN  = 5'd12;
   localparam logic [4:0] S_TR_CMP   = 5'd13;
   localparam logic [4:0] S_TR_DEC   = 5'd14;
   localparam logic [4:0] S_TR_PAR   = 5'd15;
   localparam logic [4:0] S_FIN      = 5'd16;

   logic [4:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd.op   = mmhpq_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = mmhpq_pkg::OP_ACCEPT;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.insert_cmd) begin
               if (stat.full) begin
                  cmd.op   = mmhpq_pkg::OP_INS_FULL;
                  state_in = S_FIN;
               end else begin
                  cmd.op   = mmhpq_pkg::OP_INS_START;
                  state_in = stat.empty ? S_WRX : S_INS_P;
               end
            end else if (stat.empty) begin
               cmd.op   = mmhpq_pkg::OP_EMPTY;
               state_in = S_FIN;
            end else if (stat.min_cmd) begin
               cmd.op   = mmhpq_pkg::OP_RMIN_START;
               state_in = S_RM_R;
            end else begin
               cmd.op   = mmhpq_pkg::OP_RMAX_START;
               state_in = stat.cnt_le2 ? S_RM_R : S_MX2;
            end
         end
         S_INS_P: begin
            cmd.op   = mmhpq_pkg::OP_INS_P;
            state_in = S_BUB;
         end
         S_BUB: begin
            cmd.op   = mmhpq_pkg::OP_BUB;
            state_in = stat.i_gt3 ? S_BUB_G : S_WRX;
         end
         S_BUB_G: begin
            cmd.op   = mmhpq_pkg::OP_BUB_G;
            state_in = stat.bub_swap ? S_BUB : S_WRX;
         end
         S_WRX: begin
            cmd.op   = mmhpq_pkg::OP_WRX;
            state_in = S_FIN;
         end
         S_MX2: begin
            cmd.op   = mmhpq_pkg::OP_MX2;
            state_in = S_MX3;
         end
         S_MX3: begin
            cmd.op   = mmhpq_pkg::OP_MX3;
            state_in = S_RM_L;
         end
         S_RM_R: begin
            cmd.op   = mmhpq_pkg::OP_RM_R;
            state_in = S_RM_L;
         end
         S_RM_L: begin
            cmd.op = mmhpq_pkg::OP_RM_L;
            if (!stat.mi_live) begin
               state_in = S_FIN;
            end else if (stat.mi_is1) begin
               state_in = S_TR_START;
            end else begin
               state_in = S_MX_ROOT;
            end
         end
         S_MX_ROOT: begin
            cmd.op   = mmhpq_pkg::OP_MX_ROOT;
            state_in = S_TR_START;
         end
         S_TR_START: begin
            cmd.op   = mmhpq_pkg::OP_TR_START;
            state_in = S_TR_SCAN;
         end
         S_TR_SCAN: begin
            cmd.op   = mmhpq_pkg::OP_TR_SCAN;
            state_in = (stat.k_done || !stat.cand_live) ? S_TR_DEC : S_TR_CMP;
         end
         S_TR_CMP: begin
            cmd.op   = mmhpq_pkg::OP_TR_CMP;
            state_in = S_TR_SCAN;
         end
         S_TR_DEC: begin
            cmd.op = mmhpq_pkg::OP_TR_DEC;
            if (stat.m_eq_i) begin
               state_in = S_FIN;
            end else if (stat.m_grand) begin
               state_in = S_TR_PAR;
            end else begin
               state_in = S_WRX;
            end
         end
         S_TR_PAR: begin
            cmd.op   = mmhpq_pkg::OP_TR_PAR;
            state_in = S_TR_START;
         end
         S_FIN: begin
            if (!valid_ff || rsp_ready) begin
               cmd.op   = mmhpq_pkg::OP_OUT;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// File: rtl/mmhpq_dp.sv
// Datapath of the min-max heap queue: heap memory, working registers, result register.
// Depends on mmhpq_pkg; driven by operation codes from mmhpq_ctrl.
module mmhpq_dp #(
   parameter int QUEUE_DEPTH = 1024,
   parameter int CW          = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mmhpq_pkg::ctrl_cmd_type  cmd,
   output mmhpq_pkg::dp_status_type stat,
   input  logic [1:0]               in_command,
   input  logic [30:0]              in_number,
   input  logic signed [31:0]       in_priority,
   output logic [2:0]               out_status,
   output logic [30:0]              out_number,
   output logic signed [31:0]       out_priority,
   output logic [CW-1:0]            out_count
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int SW = CW + 2;

   mmhpq_pkg::entry_type mem [QUEUE_DEPTH];

   mmhpq_pkg::entry_type rd_ff;
   mmhpq_pkg::entry_type x_ff, x_in, best_ff, best_in, res_ff, res_in;
   logic [CW-1:0] cnt_ff, cnt_in, i_ff, i_in, m_ff, m_in;
   logic [1:0]    mi_ff, mi_in, cmd_ff, cmd_in;
   logic [2:0]    k_ff, k_in, st_ff, st_in;
   logic          on_max_ff, on_max_in;
   logic [2:0]    ost_ff, ost_in;
   logic [30:0]   onum_ff, onum_in;
   logic [31:0]   opri_ff, opri_in;
   logic [CW-1:0] ocnt_ff, ocnt_in;

   logic                 rd_en, wr_en, odd_i, swap;
   logic [SW-1:0]        rd_slot, rd_off, i_sw, j_sw;
   logic [CW-1:0]        wr_slot, wr_off, cnt_inc;
   logic [AW-1:0]        rd_addr, wr_addr;
   mmhpq_pkg::entry_type wr_data;

   function automatic logic better(input logic signed [31:0] a, input logic signed [31:0] b,
                                   input logic on_max);
      return on_max ? (a > b) : (a < b);
   endfunction

   // Level parity follows the position of the leading one of the slot number.
   function automatic logic odd_level(input logic [CW-1:0] v);
      logic odd;
      odd = 1'b0;
      for (int b = 0; b < CW; b++) begin
         if (v[b]) odd = b[0];
      end
      return odd;
   endfunction

   always_comb begin
      i_sw    = SW'(i_ff);
      j_sw    = (k_ff < 3'd2) ? (i_sw << 1) + SW'(k_ff) : (i_sw << 2) + SW'(k_ff - 3'd2);
      cnt_inc = cnt_ff + CW'(1);
      odd_i   = odd_level(i_ff);

      stat.insert_cmd = (cmd_ff == mmhpq_pkg::CMD_INSERT);
      stat.min_cmd    = cmd_ff[1];
      stat.full       = (cnt_ff == CW'(QUEUE_DEPTH));
      stat.empty      = (cnt_ff == '0);
      stat.cnt_le2    = (cnt_ff <= CW'(2));
      stat.mi_live    = (CW'(mi_ff) < cnt_ff);
      stat.mi_is1     = (mi_ff == 2'd1);
      stat.k_done     = (k_ff == 3'd6);
      stat.cand_live  = (j_sw <= SW'(cnt_ff));
      stat.m_eq_i     = (m_ff == i_ff);
      stat.m_grand    = (SW'(m_ff) >= (i_sw << 2));
      stat.i_gt3      = (i_ff > CW'(3));
      stat.bub_swap   = better(x_ff.pri, rd_ff.pri, on_max_ff);
   end

   always_comb begin
      x_in      = x_ff;
      best_in   = best_ff;
      res_in    = res_ff;
      cnt_in    = cnt_ff;
      i_in      = i_ff;
      m_in      = m_ff;
      mi_in     = mi_ff;
      cmd_in    = cmd_ff;
      k_in      = k_ff;
      st_in     = st_ff;
      on_max_in = on_max_ff;
      ost_in    = ost_ff;
      onum_in   = onum_ff;
      opri_in   = opri_ff;
      ocnt_in   = ocnt_ff;
      rd_en     = 1'b0;
      rd_slot   = SW'(1);
      wr_en     = 1'b0;
      wr_slot   = i_ff;
      wr_data   = x_ff;
      swap      = 1'b0;
      case (cmd.op)
         mmhpq_pkg::OP_ACCEPT: begin
            x_in.num = in_number;
            x_in.pri = in_priority;
            cmd_in   = in_command;
            res_in   = '0;
         end
         mmhpq_pkg::OP_INS_FULL: begin
            st_in = mmhpq_pkg::ST_FULL;
         end
         mmhpq_pkg::OP_INS_START: begin
            st_in   = mmhpq_pkg::ST_INSERTED;
            cnt_in  = cnt_inc;
            i_in    = cnt_inc;
            rd_en   = 1'b1;
            rd_slot = SW'(cnt_inc) >> 1;
         end
         mmhpq_pkg::OP_EMPTY: begin
            st_in = mmhpq_pkg::ST_EMPTY;
         end
         mmhpq_pkg::OP_RMIN_START: begin
            st_in = mmhpq_pkg::ST_MIN;
            mi_in = 2'd1;
            rd_en = 1'b1;
         end
         mmhpq_pkg::OP_RMAX_START: begin
            st_in   = mmhpq_pkg::ST_MAX;
            mi_in   = (cnt_ff == CW'(1)) ? 2'd1 : 2'd2;
            rd_en   = 1'b1;
            rd_slot = (cnt_ff == CW'(1)) ? SW'(1) : SW'(2);
         end
         mmhpq_pkg::OP_MX2: begin
            best_in = rd_ff;
            rd_en   = 1'b1;
            rd_slot = SW'(3);
         end
         mmhpq_pkg::OP_MX3: begin
            // On a tie the right child is the one removed.
            if (best_ff.pri > rd_ff.pri) begin
               res_in = best_ff;
               mi_in  = 2'd2;
            end else begin
               res_in = rd_ff;
               mi_in  = 2'd3;
            end
            rd_en   = 1'b1;
            rd_slot = SW'(cnt_ff);
         end
         mmhpq_pkg::OP_RM_R: begin
            res_in  = rd_ff;
            rd_en   = 1'b1;
            rd_slot = SW'(cnt_ff);
         end
         mmhpq_pkg::OP_RM_L: begin
            x_in      = rd_ff;
            cnt_in    = cnt_ff - CW'(1);
            i_in      = CW'(mi_ff);
            on_max_in = (mi_ff != 2'd1);
            rd_en     = 1'b1;
         end
         mmhpq_pkg::OP_MX_ROOT: begin
            if (x_ff.pri < rd_ff.pri) begin
               wr_en   = 1'b1;
               wr_slot = CW'(1);
               x_in    = rd_ff;
            end
         end
         mmhpq_pkg::OP_TR_START: begin
            m_in    = i_ff;
            best_in = x_ff;
            k_in    = 3'd0;
         end
         mmhpq_pkg::OP_TR_SCAN: begin
            rd_en   = 1'b1;
            rd_slot = j_sw;
         end
         mmhpq_pkg::OP_TR_CMP: begin
            if (better(rd_ff.pri, best_ff.pri, on_max_ff)) begin
               best_in = rd_ff;
               m_in    = CW'(j_sw);
            end
            k_in = k_ff + 3'd1;
         end
         mmhpq_pkg::OP_TR_DEC: begin
            wr_en = 1'b1;
            if (m_ff != i_ff) begin
               wr_data = best_ff;
               rd_en   = 1'b1;
               rd_slot = SW'(m_ff >> 1);
               if (!stat.m_grand) i_in = m_ff;
            end
         end
         mmhpq_pkg::OP_TR_PAR: begin
            if (better(rd_ff.pri, x_ff.pri, on_max_ff)) begin
               wr_en   = 1'b1;
               wr_slot = m_ff >> 1;
               x_in    = rd_ff;
            end
            i_in = m_ff;
         end
         mmhpq_pkg::OP_INS_P: begin
            swap = odd_i ? (x_ff.pri < rd_ff.pri) : (x_ff.pri > rd_ff.pri);
            if (swap) begin
               wr_en     = 1'b1;
               wr_data   = rd_ff;
               i_in      = i_ff >> 1;
               on_max_in = !odd_i;
            end else begin
               on_max_in = odd_i;
            end
         end
         mmhpq_pkg::OP_BUB: begin
            rd_en   = 1'b1;
            rd_slot = SW'(i_ff >> 2);
         end
         mmhpq_pkg::OP_BUB_G: begin
            if (stat.bub_swap) begin
               wr_en   = 1'b1;
               wr_data = rd_ff;
               i_in    = i_ff >> 2;
            end
         end
         mmhpq_pkg::OP_WRX: begin
            wr_en = 1'b1;
         end
         mmhpq_pkg::OP_OUT: begin
            ost_in  = st_ff;
            onum_in = res_ff.num;
            opri_in = res_ff.pri;
            ocnt_in = cnt_ff;
         end
         default: begin
         end
      endcase
      rd_off  = rd_slot - SW'(1);
      rd_addr = rd_off[AW-1:0];
      wr_off  = wr_slot - CW'(1);
      wr_addr = wr_off[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      x_ff      <= x_in;
      best_ff   <= best_in;
      res_ff    <= res_in;
      i_ff      <= i_in;
      m_ff      <= m_in;
      mi_ff     <= mi_in;
      cmd_ff    <= cmd_in;
      k_ff      <= k_in;
      st_ff     <= st_in;
      on_max_ff <= on_max_in;
      ost_ff    <= ost_in;
      onum_ff   <= onum_in;
      opri_ff   <= opri_in;
      ocnt_ff   <= ocnt_in;
   end

   assign out_status   = ost_ff;
   assign out_number   = onum_ff;
   assign out_priority = opri_ff;
   assign out_count    = ocnt_ff;

endmodule

// File: rtl/min_max_heap_priority_queue_top.sv
// Min-max heap double-ended priority queue, top level. An insert into an empty queue
// goes straight to the root; otherwise it checks the parent, then climbs by level
// pairs. A removal on an empty queue only reports empty; otherwise the moved entry
// trickles down in two-level steps, one memory read per comparison.
// One command is in flight at a time: a new word is taken only in the idle state.
// Synchronous reset empties the queue at once; heap memory contents are not cleared.
module min_max_heap_priority_queue_top #(
   parameter int QUEUE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   mmhpq_req_if.sink   req_ch,
   mmhpq_rsp_if.source rsp_ch
);

   // Count width must hold the depth itself.
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   mmhpq_pkg::ctrl_cmd_type  cmd;
   mmhpq_pkg::dp_status_type stat;

   // The controller walks each command word through memory reads and writes,
   // and owns the handshake on both channels.
   mmhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the heap store, the live count and the result register.
   mmhpq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CW          (CW)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .in_command   (req_ch.command),
      .in_number    (req_ch.job_number),
      .in_priority  (req_ch.job_priority),
      .out_status   (rsp_ch.status),
      .out_number   (rsp_ch.removed_number),
      .out_priority (rsp_ch.removed_priority),
      .out_count    (rsp_ch.waiting_count)
   );

endmodule

// File: rtl/mmhpq_checker.sv
// Port-level checks of the min-max heap queue result channel, bound to the top level.
// Depends on mmhpq_pkg and the assertion macro header.
`include "min_max_heap_priority_queue_top_macros.svh"

module mmhpq_checker #(
   parameter int QUEUE_DEPTH = 1024
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [2:0]                            rsp_status,
   input logic [30:0]                           rsp_removed_number,
   input logic [31:0]                           rsp_removed_priority,
   input logic [$clog2(QUEUE_DEPTH + 1)-1:0]    rsp_waiting_count
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic count_ok, nothing_removed, zero_fields, empty_zero;

   assign count_ok        = !rsp_valid || (rsp_waiting_count <= CW'(QUEUE_DEPTH));
   assign nothing_removed = rsp_valid && (rsp_status == mmhpq_pkg::ST_INSERTED ||
                                          rsp_status == mmhpq_pkg::ST_EMPTY ||
                                          rsp_status == mmhpq_pkg::ST_FULL);
   assign zero_fields     = (rsp_removed_number == '0) && (rsp_removed_priority == '0);
   assign empty_zero      = !(rsp_valid && rsp_status == mmhpq_pkg::ST_EMPTY) ||
                            (rsp_waiting_count == '0);

   `MMHPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MMHPQ_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)
   `MMHPQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ok)
   `MMHPQ_ASSERT_ALWAYS(a_no_removal_zero, clock, reset, !nothing_removed || zero_fields)
   `MMHPQ_ASSERT_ALWAYS(a_empty_count, clock, reset, empty_zero)

endmodule

bind min_max_heap_priority_queue_top mmhpq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_mmhpq_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .rsp_status           (rsp_ch.status),
   .rsp_removed_number   (rsp_ch.removed_number),
   .rsp_removed_priority (rsp_ch.removed_priority),
   .rsp_waiting_count    (rsp_ch.waiting_count)
);

// File: bench/mmhpq_checker.sv
// Scoreboard for the min-max heap priority queue: it watches both channels,
// predicts each result and compares it. Depends on mmhpq_pkg and mmhpq_ifs.
module mmhpq_scoreboard #(
   parameter int DEPTH = 1024
) (
   input  logic  clock,
   input  logic  reset,
   mmhpq_req_if  req,
   mmhpq_rsp_if  rsp,
   output int    errors,
   output int    pending,
   output int    checked,
   output int    full_seen,
   output int    empty_seen
);

   typedef struct {
      logic [2:0]         status;
      logic [30:0]        number;
      logic signed [31:0] priority_v;
      logic [10:0]        count;
   } outcome_type;

   outcome_type awaited[$];
   int          job_id[DEPTH + 1];
   int          job_pri[DEPTH + 1];
   int          live;

   function automatic bit odd_level(int i);
      bit odd;
      odd = 0;
      while (i > 1) begin
         i = i >> 1;
         odd = !odd;
      end
      return odd;
   endfunction

   function automatic bit wins(int a, int b, bit on_max);
      return on_max ? (a > b) : (a < b);
   endfunction

   function automatic void swap_slots(int a, int b);
      int tn;
      int tp;
      tn = job_id[a];
      tp = job_pri[a];
      job_id[a] = job_id[b];
      job_pri[a] = job_pri[b];
      job_id[b] = tn;
      job_pri[b] = tp;
   endfunction

   function automatic void climb(int i, bit on_max);
      while (i > 3) begin
         if (!wins(job_pri[i], job_pri[i / 4], on_max)) break;
         swap_slots(i, i / 4);
         i = i / 4;
      end
   endfunction

   // Sinks the slot down on its own kind of level, checking children before
   // grandchildren; only a strictly better entry takes over.
   function automatic void sink(int i, bit on_max);
      int m;
      int j;
      forever begin
         m = i;
         if (2 * i <= live && wins(job_pri[2 * i], job_pri[m], on_max)) m = 2 * i;
         if (2 * i + 1 <= live && wins(job_pri[2 * i + 1], job_pri[m], on_max)) m = 2 * i + 1;
         for (int k = 0; k < 4; k++) begin
            j = 4 * i + k;
            if (j <= live && wins(job_pri[j], job_pri[m], on_max)) m = j;
         end
         if (m == i) break;
         swap_slots(i, m);
         if (m < 4 * i) break;
         if (wins(job_pri[m / 2], job_pri[m], on_max)) swap_slots(m, m / 2);
         i = m;
      end
   endfunction

   function automatic outcome_type serve(logic [1:0] cmd, logic [30:0] num, int pri);
      outcome_type o;
      int          mi;
      int          last_n;
      int          last_p;
      o.number = '0;
      o.priority_v = '0;
      if (cmd == mmhpq_pkg::CMD_INSERT) begin
         if (live >= DEPTH) begin
            o.status = mmhpq_pkg::ST_FULL;
         end else begin
            o.status = mmhpq_pkg::ST_INSERTED;
            live++;
            job_id[live] = int'(num);
            job_pri[live] = pri;
            if (live > 1) begin
               if (!odd_level(live)) begin
                  if (job_pri[live] > job_pri[live / 2]) begin
                     swap_slots(live, live / 2);
                     climb(live / 2, 1);
                  end else begin
                     climb(live, 0);
                  end
               end else begin
                  if (job_pri[live] < job_pri[live / 2]) begin
                     swap_slots(live, live / 2);
                     climb(live / 2, 0);
                  end else begin
                     climb(live, 1);
                  end
               end
            end
         end
      end else if (live == 0) begin
         o.status = mmhpq_pkg::ST_EMPTY;
      end else begin
         // Command three decodes as remove-lowest, since only bit one is looked at.
         if (cmd == mmhpq_pkg::CMD_TAKE_MAX) begin
            o.status = mmhpq_pkg::ST_MAX;
            if (live == 1) mi = 1;
            else if (live == 2) mi = 2;
            else mi = (job_pri[2] > job_pri[3]) ? 2 : 3;
         end else begin
            o.status = mmhpq_pkg::ST_MIN;
            mi = 1;
         end
         o.number = 31'(job_id[mi]);
         o.priority_v = job_pri[mi];
         last_n = job_id[live];
         last_p = job_pri[live];
         live--;
         if (mi <= live) begin
            job_id[mi] = last_n;
            job_pri[mi] = last_p;
            if (mi == 1) begin
               sink(1, 0);
            end else begin
               if (job_pri[mi] < job_pri[1]) swap_slots(mi, 1);
               sink(mi, 1);
            end
         end
      end
      o.count = 11'(live);
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         live = 0;
         awaited.delete();
         errors <= 0;
         pending <= 0;
         checked <= 0;
         full_seen <= 0;
         empty_seen <= 0;
      end else begin
         if (req.valid && req.ready)
            awaited.push_back(serve(req.command, req.job_number, req.job_priority));
         if (rsp.valid && rsp.ready) begin
            if (awaited.size() == 0) begin
               $display("%0t: result word with nothing awaited: status %0d", $time, rsp.status);
               errors <= errors + 1;
            end else begin
               want = awaited.pop_front();
               checked <= checked + 1;
               if (want.status == mmhpq_pkg::ST_FULL) full_seen <= full_seen + 1;
               if (want.status == mmhpq_pkg::ST_EMPTY) empty_seen <= empty_seen + 1;
               if (rsp.status !== want.status || rsp.removed_number !== want.number ||
                   rsp.removed_priority !== want.priority_v ||
                   rsp.waiting_count !== want.count) begin
                  $display("%0t: mismatch expected st=%0d num=%0d pri=%0d cnt=%0d",
                           $time, want.status, want.number, want.priority_v, want.count);
                  $display("%0t:          actual   st=%0d num=%0d pri=%0d cnt=%0d",
                           $time, rsp.status, rsp.removed_number, rsp.removed_priority,
                           rsp.waiting_count);
                  errors <= errors + 1;
               end
            end
         end
         pending <= awaited.size();
      end
   end

endmodule

// File: bench/tb_top.sv
// Stimulus and verdict for the min-max heap priority queue.
// Depends on mmhpq_pkg, mmhpq_ifs, mmhpq_checker and the queue's top level.
module tb_top;

   localparam int DEPTH = 1024;

   logic clock;
   logic reset;
   int   errors;
   int   pending;
   int   checked;
   int   full_seen;
   int   empty_seen;
   int   held;
   int   sent;

   mmhpq_req_if req ();
   mmhpq_rsp_if #(.CW(11)) rsp ();

   min_max_heap_priority_queue_top #(.QUEUE_DEPTH(DEPTH)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp)
   );

   mmhpq_scoreboard #(.DEPTH(DEPTH)) scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .errors     (errors),
      .pending    (pending),
      .checked    (checked),
      .full_seen  (full_seen),
      .empty_seen (empty_seen)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // The receiver alternates between stretches where it always takes the word
   // and stretches where it stalls at random.
   int  stretch = 0;
   bit  steady = 0;
   always @(posedge clock) begin
      if (stretch == 0) begin
         steady <= !steady;
         stretch <= $urandom_range(10, 150);
      end else begin
         stretch <= stretch - 1;
      end
      rsp.ready <= steady ? 1'b1 : ($urandom_range(0, 2) != 0);
   end

   // Priorities lean toward a narrow band so that ties are common, with the
   // extremes and the full range mixed in.
   function automatic logic [31:0] pick_priority();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3, 4, 5: return $urandom_range(0, 8) - 4;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] pick_number();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return 31'($urandom);
      endcase
   endfunction

   // Presents one word and holds it until the queue accepts it; valid stays
   // high so the next word may follow at once.
   task automatic push_word(logic [1:0] cmd, logic [30:0] num, logic [31:0] pri);
      req.valid <= 1'b1;
      req.command <= cmd;
      req.job_number <= num;
      req.job_priority <= pri;
      do @(posedge clock); while (!req.ready);
      sent++;
      if (cmd == mmhpq_pkg::CMD_INSERT) begin
         if (held < DEPTH) held++;
      end else if (held > 0) begin
         held--;
      end
   endtask

   task automatic pause(int cycles);
      req.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // One random word whose chance of being an insert is given in percent;
   // a few removals use the alias code three.
   task automatic random_word(int insert_pct);
      logic [1:0] cmd;
      if ($urandom_range(1, 100) <= insert_pct) cmd = mmhpq_pkg::CMD_INSERT;
      else if ($urandom_range(0, 9) == 0) cmd = mmhpq_pkg::CMD_ODD_MIN;
      else cmd = $urandom_range(0, 1) ? mmhpq_pkg::CMD_TAKE_MAX : mmhpq_pkg::CMD_TAKE_MIN;
      push_word(cmd, pick_number(), pick_priority());
   endtask

   int burst;

   task automatic maybe_gap();
      if (burst > 0) begin
         burst--;
      end else begin
         burst = $urandom_range(1, 30);
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
      end
   endtask

   initial begin
      reset = 1;
      req.valid = 0;
      req.command = mmhpq_pkg::CMD_INSERT;
      req.job_number = '0;
      req.job_priority = '0;
      held = 0;
      sent = 0;
      burst = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: removals on an empty queue, the field extremes, equal
      // priorities so the right child wins a remove-max tie, and the alias code.
      push_word(mmhpq_pkg::CMD_TAKE_MAX, '1, '1);
      push_word(mmhpq_pkg::CMD_TAKE_MIN, '1, '1);
      push_word(mmhpq_pkg::CMD_ODD_MIN, '0, '0);
      push_word(mmhpq_pkg::CMD_INSERT, '1, 32'h7fff_ffff);
      push_word(mmhpq_pkg::CMD_TAKE_MAX, '0, '0);
      push_word(mmhpq_pkg::CMD_INSERT, '0, 32'h8000_0000);
      push_word(mmhpq_pkg::CMD_INSERT, 31'd5, 32'h7fff_ffff);
      push_word(mmhpq_pkg::CMD_TAKE_MAX, '0, '0);
      push_word(mmhpq_pkg::CMD_TAKE_MIN, '0, '0);
      push_word(mmhpq_pkg::CMD_INSERT, 31'd1, 32'd7);
      push_word(mmhpq_pkg::CMD_INSERT, 31'd2, 32'd9);
      push_word(mmhpq_pkg::CMD_INSERT, 31'd3, 32'd9);
      push_word(mmhpq_pkg::CMD_INSERT, 31'd4, 32'd1);
      push_word(mmhpq_pkg::CMD_INSERT, 31'd6, 32'hffff_fff0);
      push_word(mmhpq_pkg::CMD_INSERT, 31'd8, 32'd9);
      push_word(mmhpq_pkg::CMD_TAKE_MAX, '0, '0);
      push_word(mmhpq_pkg::CMD_TAKE_MAX, '0, '0);
      push_word(mmhpq_pkg::CMD_ODD_MIN, '0, '0);
      push_word(mmhpq_pkg::CMD_TAKE_MIN, '0, '0);
      push_word(mmhpq_pkg::CMD_TAKE_MAX, '0, '0);
      push_word(mmhpq_pkg::CMD_TAKE_MIN, '0, '0);
      push_word(mmhpq_pkg::CMD_TAKE_MIN, '0, '0);

      // Mixed traffic on a small heap.
      repeat (150) begin
         maybe_gap();
         random_word(55);
      end

      // Grow to a full queue, then knock on it a few more times.
      while (held < DEPTH) begin
         maybe_gap();
         random_word(98);
      end
      repeat (6) push_word(mmhpq_pkg::CMD_INSERT, pick_number(), pick_priority());

      // Let every outstanding result drain before a long run of removals.
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      repeat (600) begin
         maybe_gap();
         random_word(10);
      end
      repeat (4) push_word(2'($urandom_range(1, 3)), pick_number(), pick_priority());

      repeat (100) begin
         maybe_gap();
         random_word(60);
      end

      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Sent %0d command words and checked %0d results,", sent, checked);
      $display("including %0d full-queue and %0d empty-queue replies.", full_seen, empty_seen);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Timed out with %0d results outstanding.", pending);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/mmhpq_pkg.sv
rtl/mmhpq_ifs.sv
rtl/mmhpq_ctrl.sv
rtl/mmhpq_dp.sv
rtl/min_max_heap_priority_queue_top.sv
rtl/mmhpq_checker.sv
bench/mmhpq_checker.sv
bench/tb_top.sv
